/* rtl/functional_graph_cycle_entry_core_macros.svh */
// Assertion macros shared by the cycle entry RTL.
`ifndef FUNCTIONAL_GRAPH_CYCLE_ENTRY_CORE_MACROS_SVH
`define FUNCTIONAL_GRAPH_CYCLE_ENTRY_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FGCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FGCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fgce_pkg.sv */
// Shared types, constants and microcode program of the cycle entry block.
package fgce_pkg;

    // Field widths
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int EPOCH_W = 8;
    localparam int STEP_W  = 4;

    // Nodes addressable by a 10-bit index
    localparam int IDX_SPAN = 1 << IDX_W;

    localparam int                MAX_NODES_DEFAULT = 1024;
    localparam logic [CNT_W-1:0]  NODE_COUNT_RESET  = CNT_W'(1024);

    // Datapath operations issued by the control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_WALK,
        OP_ERROR,
        OP_PUSH,
        OP_WRITE,
        OP_CLEAR,
        OP_EPOCH_RESET
    } uop_e;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_REQ,
        COND_BAD,
        COND_LOAD,
        COND_WALK_GO,
        COND_OUT_BUSY,
        COND_EPOCH_FREE,
        COND_CLEAR_MORE
    } cond_e;

    // Microprogram step addresses
    typedef enum logic [STEP_W-1:0] {
        ST_WAIT,
        ST_DECODE,
        ST_KIND,
        ST_START,
        ST_WALK,
        ST_RESULT,
        ST_EPOCH,
        ST_CLEAR,
        ST_CLEAR_END,
        ST_LOAD,
        ST_ERROR
    } step_e;

    typedef struct packed {
        logic  in_ready;
        uop_e  op;
        cond_e cond;
        step_e target;
    } ucode_t;

    // Control from sequencer to datapath
    typedef struct packed {
        logic in_ready;
        uop_e op;
    } fgce_ctrl_t;

    // Status flags from datapath to sequencer
    typedef struct packed {
        logic no_req;
        logic bad;
        logic is_load;
        logic walk_go;
        logic out_busy;
        logic epoch_free;
        logic clear_more;
    } fgce_status_t;

    // Microcode ROM: when cond holds jump to target, else fall to the next step
    function automatic ucode_t ucode_word(input step_e step);
        ucode_t w;
        begin
            w = '{in_ready: 1'b0, op: OP_NONE, cond: COND_ALWAYS, target: ST_WAIT};
            unique case (step)
                ST_WAIT:      w = '{1'b1, OP_NONE,        COND_NO_REQ,     ST_WAIT};
                ST_DECODE:    w = '{1'b0, OP_NONE,        COND_BAD,        ST_ERROR};
                ST_KIND:      w = '{1'b0, OP_NONE,        COND_LOAD,       ST_LOAD};
                ST_START:     w = '{1'b0, OP_START,       COND_ALWAYS,     ST_WALK};
                ST_WALK:      w = '{1'b0, OP_WALK,        COND_WALK_GO,    ST_WALK};
                ST_RESULT:    w = '{1'b0, OP_PUSH,        COND_OUT_BUSY,   ST_RESULT};
                ST_EPOCH:     w = '{1'b0, OP_NONE,        COND_EPOCH_FREE, ST_WAIT};
                ST_CLEAR:     w = '{1'b0, OP_CLEAR,       COND_CLEAR_MORE, ST_CLEAR};
                ST_CLEAR_END: w = '{1'b0, OP_EPOCH_RESET, COND_ALWAYS,     ST_WAIT};
                ST_LOAD:      w = '{1'b0, OP_WRITE,       COND_ALWAYS,     ST_WAIT};
                ST_ERROR:     w = '{1'b0, OP_ERROR,       COND_ALWAYS,     ST_RESULT};
                default:      w = '{1'b0, OP_NONE,        COND_ALWAYS,     ST_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/fgce_if.sv */
// Channel interfaces: configuration write, request and response.

// Configuration write channel
interface fgce_cfg_if import fgce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] node_count;

    modport source (output valid, output node_count, input ready);
    modport sink   (input valid, input node_count, output ready);
endinterface

// Request channel
interface fgce_req_if import fgce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] successor;

    modport source (output valid, output action, output node, output successor, input ready);
    modport sink   (input valid, input action, input node, input successor, output ready);
endinterface

// Response channel
interface fgce_rsp_if import fgce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] answer;
    logic             error;

    modport source (output valid, output answer, output error, input ready);
    modport sink   (input valid, input answer, input error, output ready);
endinterface

/* rtl/functional_graph_cycle_entry_core.sv */
// Top level of the functional graph cycle entry block.
//
// Channels: cfg writes node_count (always ready); req carries one request
// (action, node, successor); rsp returns answer and error. A request moves
// on a clock edge with valid and ready both high.
// A load request writes one successor entry and returns nothing, unless an
// index is out of range, in which case one response with error set follows.
// A query request walks the successor table from node, one table read per
// cycle, and returns the first node seen twice.
// The walk loop is set by the single read port of the successor table and
// the visited tag memory.
// Visited marks are epoch tags; every 255 in-range queries, and after reset,
// a clearing pass over min(MAX_NODES, 1024) tag entries runs with req not ready.
// Reset: rst_n is asynchronous, active low; node_count returns to 1024 and
// the successor table holds no defined contents until loaded.
// Stall: the response sits in an output register until taken; the block
// holds in its result step while a previous response is still waiting.
module functional_graph_cycle_entry_core import fgce_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    fgce_cfg_if.sink   cfg,
    fgce_req_if.sink   req,
    fgce_rsp_if.source rsp
);

    fgce_ctrl_t   ctrl;
    fgce_status_t status;

    // Microprogram control
    fgce_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Tables, walk registers and channels
    fgce_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .status (status),
        .cfg    (cfg),
        .req    (req),
        .rsp    (rsp)
    );

endmodule

/* rtl/fgce_sequencer.sv */
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
module fgce_sequencer import fgce_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  fgce_status_t status,
    output fgce_ctrl_t   ctrl
);

    step_e  step_reg;
    step_e  step_next;
    ucode_t word;
    logic   cond_true;

    // Current control word
    assign word = ucode_word(step_reg);

    // Jump condition select
    always_comb
    begin
        unique case (word.cond)
            COND_ALWAYS:     cond_true = 1'b1;
            COND_NO_REQ:     cond_true = status.no_req;
            COND_BAD:        cond_true = status.bad;
            COND_LOAD:       cond_true = status.is_load;
            COND_WALK_GO:    cond_true = status.walk_go;
            COND_OUT_BUSY:   cond_true = status.out_busy;
            COND_EPOCH_FREE: cond_true = status.epoch_free;
            COND_CLEAR_MORE: cond_true = status.clear_more;
            default:         cond_true = 1'b1;
        endcase
    end

    // Next step
    always_comb
    begin
        if (cond_true)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_e'(step_reg + 1'b1);
        end
    end

    // Outputs to the datapath
    always_comb
    begin
        ctrl.in_ready = word.in_ready;
        ctrl.op       = word.op;
    end

    // Step counter; reset starts with the tag clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* rtl/fgce_datapath.sv */
// Datapath: node count, successor table, visited tags, walk and result registers.
module fgce_datapath import fgce_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  fgce_ctrl_t   ctrl,
    output fgce_status_t status,
    fgce_cfg_if.sink     cfg,
    fgce_req_if.sink     req,
    fgce_rsp_if.source   rsp
);

    `include "functional_graph_cycle_entry_core_macros.svh"

    // Only 10-bit indices exist, so storage stops at IDX_SPAN entries
    localparam int DEPTH = (MAX_NODES < IDX_SPAN) ? MAX_NODES : IDX_SPAN;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

    // Memories
    logic [AW-1:0]      succ_mem [DEPTH];
    logic [EPOCH_W-1:0] tag_mem  [DEPTH];

    // Control registers
    logic [CNT_W-1:0]   node_count_reg, node_count_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               byp_reg, byp_next;

    // Payload registers
    logic               action_reg;
    logic [IDX_W-1:0]   node_reg;
    logic [IDX_W-1:0]   succ_reg;
    logic [AW-1:0]      pos_reg;
    logic [IDX_W-1:0]   res_answer_reg;
    logic               res_error_reg;
    logic [IDX_W-1:0]   out_answer_reg;
    logic               out_error_reg;
    logic [AW-1:0]      succ_rd_reg;
    logic [EPOCH_W-1:0] tag_rd_reg;

    // Combinational
    logic [CNT_W-1:0]   lim;
    logic               req_fire;
    logic               hit;
    logic               next_ok;
    logic               node_bad;
    logic               succ_bad;
    logic               out_busy;
    logic               push;
    logic [AW-1:0]      rd_addr;
    logic               tag_we;
    logic [AW-1:0]      tag_wa;
    logic [EPOCH_W-1:0] tag_wd;
    logic               succ_we;

    // Handshakes
    assign cfg.ready = 1'b1;
    assign req.ready = ctrl.in_ready;
    assign req_fire  = req.valid && req.ready;

    // Active node limit
    assign lim = (node_count_reg > DEPTH_CNT) ? DEPTH_CNT : node_count_reg;

    // Range checks on the held request
    assign node_bad = CNT_W'(node_reg) >= lim;
    assign succ_bad = CNT_W'(succ_reg) >= lim;

    // Walk step: revisit, or a successor outside the limit
    assign hit     = (tag_rd_reg == epoch_reg) || byp_reg;
    assign next_ok = CNT_W'(succ_rd_reg) < lim;

    // Output register
    assign out_busy   = out_valid_reg && !rsp.ready;
    assign push       = (ctrl.op == OP_PUSH) && !out_busy;
    assign rsp.valid  = out_valid_reg;
    assign rsp.answer = out_answer_reg;
    assign rsp.error  = out_error_reg;

    // Status to the sequencer
    always_comb
    begin
        status.no_req     = !req_fire;
        status.bad        = action_reg ? node_bad : (node_bad || succ_bad);
        status.is_load    = !action_reg;
        status.walk_go    = !hit && next_ok;
        status.out_busy   = out_busy;
        status.epoch_free = epoch_reg != '1;
        status.clear_more = clr_cnt_reg != LAST_ADDR;
    end

    // Memory addressing
    always_comb
    begin
        rd_addr = (ctrl.op == OP_START) ? node_reg[AW-1:0] : succ_rd_reg;
        tag_we  = 1'b0;
        tag_wa  = pos_reg;
        tag_wd  = epoch_reg;
        unique case (ctrl.op)
            OP_WALK:
            begin
                tag_we = !hit;
            end
            OP_CLEAR:
            begin
                tag_we = 1'b1;
                tag_wa = clr_cnt_reg;
                tag_wd = '0;
            end
            default:
            begin
                tag_we = 1'b0;
            end
        endcase
        succ_we = ctrl.op == OP_WRITE;
    end

    // Next values of control registers
    always_comb
    begin
        node_count_next = cfg.valid ? cfg.node_count : node_count_reg;

        unique case (ctrl.op)
            OP_START:       epoch_next = epoch_reg + 1'b1;
            OP_EPOCH_RESET: epoch_next = '0;
            default:        epoch_next = epoch_reg;
        endcase

        if (ctrl.op == OP_CLEAR)
        begin
            clr_cnt_next = (clr_cnt_reg == LAST_ADDR) ? '0 : clr_cnt_reg + 1'b1;
        end
        else
        begin
            clr_cnt_next = clr_cnt_reg;
        end

        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        // Tag written this cycle at the address being read
        byp_next = (ctrl.op == OP_WALK) && tag_we && (tag_wa == rd_addr);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            epoch_reg      <= '0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            byp_reg        <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            epoch_reg      <= epoch_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
            byp_reg        <= byp_next;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            action_reg <= req.action;
            node_reg   <= req.node;
            succ_reg   <= req.successor;
        end
    end

    // Walk position and pending result
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_START:
            begin
                pos_reg <= node_reg[AW-1:0];
            end
            OP_WALK:
            begin
                if (hit)
                begin
                    res_answer_reg <= IDX_W'(pos_reg);
                    res_error_reg  <= 1'b0;
                end
                else if (!next_ok)
                begin
                    res_answer_reg <= '0;
                    res_error_reg  <= 1'b1;
                end
                else
                begin
                    pos_reg <= succ_rd_reg;
                end
            end
            OP_ERROR:
            begin
                res_answer_reg <= '0;
                res_error_reg  <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_answer_reg <= res_answer_reg;
            out_error_reg  <= res_error_reg;
        end
    end

    // Successor table
    always_ff @(posedge clk)
    begin
        if (succ_we)
        begin
            succ_mem[node_reg[AW-1:0]] <= succ_reg[AW-1:0];
        end
        succ_rd_reg <= succ_mem[rd_addr];
    end

    // Visited tags: an entry is visited when its tag equals the current epoch
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
        tag_rd_reg <= tag_mem[rd_addr];
    end

    // Checks
    `FGCE_ASSERT_SAME(a_walk_epoch_live, ctrl.op == OP_WALK, epoch_reg != '0, "walk with cleared epoch")
    `FGCE_ASSERT_SAME(a_walk_pos_range, ctrl.op == OP_WALK, CNT_W'(pos_reg) < lim, "walk position out of range")
    `FGCE_ASSERT_SAME(a_start_after_clear, ctrl.op == OP_START, clr_cnt_reg == '0, "query during clearing pass")
    `FGCE_ASSERT_SAME(a_push_origin, $rose(out_valid_reg), $past(ctrl.op == OP_PUSH), "response without push")

endmodule

/* tb/tb_functional_graph_cycle_entry_core.sv */
// Self-checking testbench for the functional graph cycle entry core: loads, walks, range errors.
`timescale 1ns / 1ps

module tb_functional_graph_cycle_entry_core;
    import fgce_pkg::*;

    // Request action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam int RANDOM_ITEMS = 560;
    localparam int DRAIN_LIMIT  = 40000;

    typedef struct packed {
        logic [IDX_W-1:0] answer;
        logic             error;
    } cycle_rsp_t;

    // Scoreboard: successor table mirror, node count and pending responses
    class cycle_entry_scoreboard;
        logic [IDX_W-1:0] succ_tbl [IDX_SPAN];
        bit               loaded [IDX_SPAN];
        logic [CNT_W-1:0] node_count;
        cycle_rsp_t       answers_q[$];
        int               fails;
        int               n_loads;
        int               n_queries;
        int               n_errors;
        int               n_checked;

        function new();
            node_count = NODE_COUNT_RESET;
            fails      = 0;
            n_loads    = 0;
            n_queries  = 0;
            n_errors   = 0;
            n_checked  = 0;
        endfunction

        function int unsigned limit();
            if (node_count > MAX_NODES_DEFAULT)
                return MAX_NODES_DEFAULT;
            return node_count;
        endfunction

        function int pending();
            return answers_q.size();
        endfunction

        // Follow successors from start until a node repeats; start must be in range.
        // hole is the first never-loaded entry the walk would read, or -1.
        function void walk(input logic [IDX_W-1:0] start, output logic [IDX_W-1:0] ans,
                           output logic err, output int hole);
            bit          seen [IDX_SPAN];
            int unsigned pos;
            int unsigned lim;
            int unsigned k;
            lim  = limit();
            hole = -1;
            ans  = '0;
            err  = 1'b1;
            pos  = start;
            for (k = 0; k <= lim; k++)
            begin
                if (seen[pos])
                begin
                    ans = pos[IDX_W-1:0];
                    err = 1'b0;
                    return;
                end
                seen[pos] = 1'b1;
                if (!loaded[pos])
                begin
                    hole = pos;
                    return;
                end
                // walk left the active range
                if (succ_tbl[pos] >= lim)
                    return;
                pos = succ_tbl[pos];
            end
        endfunction

        // Accepted request: update the mirror and queue any response
        function void note(input logic act, input logic [IDX_W-1:0] nd,
                           input logic [IDX_W-1:0] sc);
            int unsigned lim;
            cycle_rsp_t  rsp;
            int          hole;
            lim = limit();
            rsp = '{answer: '0, error: 1'b1};
            if (act == ACT_LOAD)
            begin
                n_loads++;
                if (nd < lim && sc < lim)
                begin
                    succ_tbl[nd] = sc;
                    loaded[nd]   = 1'b1;
                    return;
                end
            end
            else
            begin
                n_queries++;
                if (nd < lim)
                begin
                    walk(nd, rsp.answer, rsp.error, hole);
                    if (hole >= 0)
                        $error("query of node %0d reads unloaded entry %0d", nd, hole);
                end
            end
            answers_q.push_back(rsp);
        endfunction

        // Accepted response against the oldest expectation
        function void check(input logic [IDX_W-1:0] ans, input logic err);
            cycle_rsp_t exp_rsp;
            if (answers_q.size() == 0)
            begin
                $error("unexpected response: answer %0d error %0d", ans, err);
                fails++;
                return;
            end
            exp_rsp = answers_q.pop_front();
            n_checked++;
            if (exp_rsp.error)
                n_errors++;
            if (ans !== exp_rsp.answer)
            begin
                $error("answer mismatch: expected %0d, actual %0d", exp_rsp.answer, ans);
                fails++;
            end
            if (err !== exp_rsp.error)
            begin
                $error("error mismatch: expected %0d, actual %0d", exp_rsp.error, err);
                fails++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    fgce_cfg_if cfg_ch();
    fgce_req_if req_ch();
    fgce_rsp_if rsp_ch();

    cycle_entry_scoreboard sb = new();

    int send_idle  = 9;
    int recv_idle  = 81;
    int items_sent = 0;
    int settings   = 0;

    functional_graph_cycle_entry_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Response side backpressure
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check(rsp_ch.answer, rsp_ch.error);
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("FAIL functional_graph_cycle_entry_core");
        $finish;
    end

    // Idle profiles: 0 light sender / heavy receiver, 1 the reverse, 2 none
    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                send_idle = 9;
                recv_idle = 81;
            end
            1:
            begin
                send_idle = 81;
                recv_idle = 9;
            end
            default:
            begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
    endtask

    // One request; called and returns at a falling edge
    task automatic send_req(input logic act, input logic [IDX_W-1:0] nd,
                            input logic [IDX_W-1:0] sc);
        while ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.node      <= nd;
        req_ch.successor <= sc;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note(act, nd, sc);
        items_sent++;
        @(negedge clk);
    endtask

    // Let every response arrive and the block return to its wait state
    task automatic wait_drain();
        int spin;
        spin = 0;
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0 && spin < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spin++;
        end
        if (sb.pending() != 0)
        begin
            $error("%0d responses never arrived", sb.pending());
            sb.fails += sb.pending();
            sb.answers_q.delete();
        end
        // loads answer nothing; give the last one time to retire
        repeat (12) @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.node_count <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.node_count = value;
        settings++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Successor in range, often one that is already loaded so walks close early
    function automatic logic [IDX_W-1:0] pick_successor();
        int unsigned lim;
        int unsigned cand;
        lim  = sb.limit();
        cand = $urandom_range(lim - 1);
        if ($urandom_range(1) == 1)
            repeat (4)
                if (!sb.loaded[cand])
                    cand = $urandom_range(lim - 1);
        return cand[IDX_W-1:0];
    endfunction

    // Load every entry a query from nd would read before it is loaded
    task automatic fill_path(input logic [IDX_W-1:0] nd);
        logic [IDX_W-1:0] ans;
        logic             err;
        int               hole;
        forever
        begin
            sb.walk(nd, ans, err, hole);
            if (hole < 0)
                break;
            send_req(ACT_LOAD, hole[IDX_W-1:0], pick_successor());
        end
    endtask

    task automatic random_item();
        int unsigned      lim;
        int unsigned      pick;
        logic             act;
        logic [IDX_W-1:0] nd;
        logic [IDX_W-1:0] sc;
        lim  = sb.limit();
        pick = $urandom_range(99);
        if (lim == 0 || pick < 12)
        begin
            // noise: any value of every field
            act = 1'($urandom_range(1));
            nd  = IDX_W'($urandom_range(IDX_SPAN - 1));
            sc  = IDX_W'($urandom_range(IDX_SPAN - 1));
            if (act == ACT_QUERY && nd < lim)
                fill_path(nd);
            send_req(act, nd, sc);
        end
        else if (pick < 40)
        begin
            nd = IDX_W'($urandom_range(lim - 1));
            send_req(ACT_LOAD, nd, pick_successor());
        end
        else
        begin
            nd = IDX_W'($urandom_range(lim - 1));
            fill_path(nd);
            send_req(ACT_QUERY, nd, IDX_W'($urandom_range(IDX_SPAN - 1)));
        end
    endtask

    // Main sequence
    initial
    begin
        int phase_counts [9];
        int target;
        int p;

        phase_counts      = '{8, 1024, 3, 2047, 300, 1, 40, 16, 1024};
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.node_count = '0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_LOAD;
        req_ch.node       = '0;
        req_ch.successor  = '0;
        rsp_ch.ready      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        set_idle(0);

        // Directed: cycles, self loop, tail into a cycle at the reset node count
        send_req(ACT_LOAD, 10'd1023, 10'd0);
        send_req(ACT_LOAD, 10'd0, 10'd1023);
        send_req(ACT_QUERY, 10'd0, 10'h2AA);
        send_req(ACT_QUERY, 10'd1023, 10'h155);
        send_req(ACT_LOAD, 10'd5, 10'd0);
        send_req(ACT_QUERY, 10'd5, 10'd1023);
        send_req(ACT_LOAD, 10'd512, 10'd512);
        send_req(ACT_QUERY, 10'd512, 10'd0);
        send_req(ACT_LOAD, 10'd700, 10'd5);
        send_req(ACT_QUERY, 10'd700, 10'd0);

        // Directed: out of range node, successor, and a walk that leaves the range
        wait_drain();
        write_count(11'd600);
        send_req(ACT_QUERY, 10'd700, 10'd0);
        send_req(ACT_LOAD, 10'd3, 10'd700);
        send_req(ACT_LOAD, 10'd700, 10'd3);
        send_req(ACT_QUERY, 10'd5, 10'd0);

        // Directed: zero node count rejects everything
        wait_drain();
        write_count(11'd0);
        send_req(ACT_LOAD, 10'd0, 10'd0);
        send_req(ACT_QUERY, 10'd0, 10'd0);

        // Directed: single node
        wait_drain();
        write_count(11'd1);
        send_req(ACT_LOAD, 10'd0, 10'd0);
        send_req(ACT_QUERY, 10'd0, 10'd1023);
        send_req(ACT_LOAD, 10'd0, 10'd1);
        send_req(ACT_QUERY, 10'd1023, 10'd1023);

        // Random phases, one node count each, idle profile per third
        target = items_sent;
        for (p = 0; p < 9; p++)
        begin
            wait_drain();
            set_idle(p / 3);
            write_count(phase_counts[p][CNT_W-1:0]);
            target += RANDOM_ITEMS / 9;
            while (items_sent < target)
                random_item();
        end

        wait_drain();
        $display("Covered %0d requests: %0d loads, %0d queries over %0d node count settings;",
                 items_sent, sb.n_loads, sb.n_queries, settings);
        $display("checked %0d responses, %0d of them range errors.",
                 sb.n_checked, sb.n_errors);
        if (sb.fails == 0)
            $display("PASS functional_graph_cycle_entry_core");
        else
            $display("FAIL functional_graph_cycle_entry_core");
        $finish;
    end

endmodule
